@@ hw/rtl/rtt_pkg.sv @@
// ----------------------------------------------------------------------------
// Retransmit timer table package
// Shared sizes, codes, state type and result record of the timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int MAX_OUT     = 16;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NOUT_W  = $clog2(MAX_OUT + 1);
    localparam int TIME_W  = 40;
    localparam int DELAY_W = 20;
    localparam int RET_W   = 3;
    localparam int ID_W    = 32;
    localparam int OTAG_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [FUNC_W-1:0] FUNC_TRACK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESV  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NEW      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPLACED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACKED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESEND   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd5;

    localparam logic [DELAY_W-1:0] RST_FIRST_DELAY = 20'd2000;
    localparam logic [DELAY_W-1:0] RST_DELAY_ONE   = 20'd4000;
    localparam logic [DELAY_W-1:0] RST_DELAY_TWO   = 20'd8000;
    localparam logic [DELAY_W-1:0] RST_DELAY_THREE = 20'd16000;
    localparam logic [DELAY_W-1:0] RST_DELAY_FOUR  = 20'd32000;
    localparam logic [RET_W-1:0]   RST_RETRY_LIMIT = 3'd5;

    localparam logic [RET_W-1:0] SCHED_TOP = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_COMMIT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [OTAG_W-1:0] tag;
        logic [RET_W-1:0]  retries;
    } t_result;

endpackage

@@ hw/rtl/rtt_req_if.sv @@
// ----------------------------------------------------------------------------
// Timer table request channel
// Valid/ready channel that carries one command to the timer table.
// ----------------------------------------------------------------------------
interface rtt_req_if
    import rtt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   msg_id;
    logic [OTAG_W-1:0] payload_tag;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, func, msg_id, payload_tag, now_ms, input ready);
    modport sink   (input valid, func, msg_id, payload_tag, now_ms, output ready);
endinterface

@@ hw/rtl/rtt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Timer table result channel
// Valid/ready channel that carries one result record from the timer table.
// ----------------------------------------------------------------------------
interface rtt_rsp_if
    import rtt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_id;
    logic [OTAG_W-1:0] out_tag;
    logic [RET_W-1:0]  out_retries;
    logic              last;

    modport source (output valid, kind, out_id, out_tag, out_retries, last, input ready);
    modport sink   (input valid, kind, out_id, out_tag, out_retries, last, output ready);
endinterface

@@ hw/rtl/retransmit_timer_table.sv @@
// ----------------------------------------------------------------------------
// Retransmit timer table
// Tracks unacknowledged messages with due times and exponential backoff.
// ----------------------------------------------------------------------------
// One command is handled at a time. A sequencer walks the TABLE_DEPTH slots
// in order through a single id/due comparator and a single saturating 40-bit
// time adder. Track and ack pass through accept, a scan of up to TABLE_DEPTH
// slots (the scan stops at a matching id), commit and flush. Tick passes
// through accept, a scan of all slots with an update step for each due entry,
// and flush. Update and flush wait while a pending result cannot move to the
// output register. Results leave through a pending stage and an output
// register; last is set on the final result of a command. A tick with nothing
// due gives no result. Configuration must be written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module retransmit_timer_table
    import rtt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rtt_req_if.sink               i_req,
    rtt_rsp_if.source             o_rsp
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state r_state, n_state;

    logic [DELAY_W-1:0] r_first, r_d1, r_d2, r_d3, r_d4;
    logic [RET_W-1:0]   r_limit;

    logic [TABLE_DEPTH-1:0] r_slot_valid;
    logic [ID_W-1:0]        r_slot_id  [TABLE_DEPTH];
    logic [TAG_BITS-1:0]    r_slot_tag [TABLE_DEPTH];
    logic [TIME_W-1:0]      r_slot_due [TABLE_DEPTH];
    logic [RET_W-1:0]       r_slot_ret [TABLE_DEPTH];

    logic [FUNC_W-1:0]   r_func;
    logic [ID_W-1:0]     r_id;
    logic [TAG_BITS-1:0] r_tag;
    logic [TIME_W-1:0]   r_now;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [TAG_BITS-1:0] r_hit_tag, n_hit_tag;
    logic [RET_W-1:0]    r_hit_ret, n_hit_ret;
    logic                r_free_v, n_free_v;
    logic [IDX_W-1:0]    r_free, n_free;
    logic [NOUT_W-1:0]   r_nout, n_nout;

    logic    r_pend_v, n_pend_v;
    t_result r_pend, n_pend;
    logic    r_out_v, n_out_v;
    t_result r_out, n_out;
    logic    r_out_last, n_out_last;

    logic                w_accept;
    logic                w_sv;
    logic [ID_W-1:0]     w_sid;
    logic [TAG_BITS-1:0] w_stag;
    logic [TIME_W-1:0]   w_sdue;
    logic [RET_W-1:0]    w_sret;
    logic                w_id_eq;
    logic                w_due;
    logic                w_last_idx;
    logic                w_out_free;
    logic                w_can_push;
    logic                w_drop;
    logic [DELAY_W-1:0]  w_addend;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_new_due;

    logic                w_wr;
    logic                w_vset;
    logic                w_vclr;
    logic [IDX_W-1:0]    w_waddr;
    logic [ID_W-1:0]     w_wid;
    logic [TAG_BITS-1:0] w_wtag;
    logic [RET_W-1:0]    w_wret;

    assign i_req.ready       = (r_state == ST_IDLE);
    assign w_accept          = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_out_v;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.out_id      = r_out.id;
    assign o_rsp.out_tag     = r_out.tag;
    assign o_rsp.out_retries = r_out.retries;
    assign o_rsp.last        = r_out_last;

    assign w_sv       = r_slot_valid[r_idx];
    assign w_sid      = r_slot_id[r_idx];
    assign w_stag     = r_slot_tag[r_idx];
    assign w_sdue     = r_slot_due[r_idx];
    assign w_sret     = r_slot_ret[r_idx];
    assign w_id_eq    = w_sv && (w_sid == r_id);
    assign w_due      = w_sv && (r_now >= w_sdue) && (r_nout < NOUT_W'(MAX_OUT));
    assign w_last_idx = (r_idx == LAST_IDX);
    assign w_out_free = !r_out_v || o_rsp.ready;
    assign w_can_push = !r_pend_v || w_out_free;
    assign w_drop     = (w_sret >= r_limit);

    // shared saturating time adder
    always_comb begin
        if (r_state == ST_COMMIT) begin
            w_addend = r_first;
        end else if (w_sret >= SCHED_TOP) begin
            w_addend = r_d4;
        end else if (w_sret == RET_W'(2)) begin
            w_addend = r_d3;
        end else if (w_sret == RET_W'(1)) begin
            w_addend = r_d2;
        end else begin
            w_addend = r_d1;
        end
    end

    assign w_sum     = {1'b0, r_now} + (TIME_W + 1)'(w_addend);
    assign w_new_due = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.func != FUNC_RESV)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_func == FUNC_TICK) begin
                    if (w_due) begin
                        n_state = ST_UPDATE;
                    end else if (w_last_idx) begin
                        n_state = ST_FLUSH;
                    end
                end else if (w_id_eq || w_last_idx) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_UPDATE: begin
                if (w_can_push) begin
                    n_state = w_last_idx ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_COMMIT: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_pend_v || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and table write controls
    always_comb begin
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_hit_tag  = r_hit_tag;
        n_hit_ret  = r_hit_ret;
        n_free_v   = r_free_v;
        n_free     = r_free;
        n_nout     = r_nout;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        w_wr       = 1'b0;
        w_vset     = 1'b0;
        w_vclr     = 1'b0;
        w_waddr    = r_idx;
        w_wid      = w_sid;
        w_wtag     = w_stag;
        w_wret     = w_sret;

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_free_v = 1'b0;
                    n_nout   = '0;
                end
            end
            ST_SCAN: begin
                if (r_func == FUNC_TICK) begin
                    if (!w_due && !w_last_idx) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (w_id_eq) begin
                    n_hit     = 1'b1;
                    n_slot    = r_idx;
                    n_hit_tag = w_stag;
                    n_hit_ret = w_sret;
                end else begin
                    if (!w_sv && !r_free_v) begin
                        n_free_v = 1'b1;
                        n_free   = r_idx;
                    end
                    if (!w_last_idx) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_UPDATE: begin
                if (w_can_push) begin
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                    end
                    n_pend_v        = 1'b1;
                    n_pend.id       = w_sid;
                    n_pend.tag      = OTAG_W'(w_stag);
                    n_nout          = r_nout + NOUT_W'(1);
                    if (w_drop) begin
                        n_pend.kind    = KIND_DROPPED;
                        n_pend.retries = w_sret;
                        w_vclr         = 1'b1;
                    end else begin
                        n_pend.kind    = KIND_RESEND;
                        n_pend.retries = w_sret + RET_W'(1);
                        w_wr           = 1'b1;
                        w_wret         = w_sret + RET_W'(1);
                    end
                    if (!w_last_idx) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_COMMIT: begin
                n_pend_v = 1'b1;
                n_pend.id = r_id;
                if (r_func == FUNC_TRACK) begin
                    n_pend.tag     = OTAG_W'(r_tag);
                    n_pend.retries = '0;
                    w_waddr        = r_hit ? r_slot : r_free;
                    w_wid          = r_id;
                    w_wtag         = r_tag;
                    w_wret         = '0;
                    if (r_hit || r_free_v) begin
                        n_pend.kind = r_hit ? KIND_REPLACED : KIND_NEW;
                        w_wr        = 1'b1;
                        w_vset      = 1'b1;
                    end else begin
                        n_pend.kind = KIND_FULL;
                    end
                end else if (r_hit) begin
                    n_pend.kind    = KIND_ACKED;
                    n_pend.tag     = OTAG_W'(r_hit_tag);
                    n_pend.retries = r_hit_ret;
                    w_waddr        = r_slot;
                    w_vclr         = 1'b1;
                end else begin
                    n_pend.kind    = KIND_UNKNOWN;
                    n_pend.tag     = '0;
                    n_pend.retries = '0;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v && w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_slot_valid <= '0;
            r_first      <= RST_FIRST_DELAY;
            r_d1         <= RST_DELAY_ONE;
            r_d2         <= RST_DELAY_TWO;
            r_d3         <= RST_DELAY_THREE;
            r_d4         <= RST_DELAY_FOUR;
            r_limit      <= RST_RETRY_LIMIT;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (w_vset) begin
                r_slot_valid[w_waddr] <= 1'b1;
            end else if (w_vclr) begin
                r_slot_valid[w_waddr] <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_DELAY: r_first <= i_cfg_data;
                    CFG_DELAY_ONE:   r_d1    <= i_cfg_data;
                    CFG_DELAY_TWO:   r_d2    <= i_cfg_data;
                    CFG_DELAY_THREE: r_d3    <= i_cfg_data;
                    CFG_DELAY_FOUR:  r_d4    <= i_cfg_data;
                    CFG_RETRY_LIMIT: r_limit <= i_cfg_data[RET_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_req.func;
            r_id   <= i_req.msg_id;
            r_tag  <= TAG_BITS'(i_req.payload_tag);
            r_now  <= i_req.now_ms;
        end
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_hit_tag  <= n_hit_tag;
        r_hit_ret  <= n_hit_ret;
        r_free_v   <= n_free_v;
        r_free     <= n_free;
        r_nout     <= n_nout;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot_id[w_waddr]  <= w_wid;
            r_slot_tag[w_waddr] <= w_wtag;
            r_slot_due[w_waddr] <= w_new_due;
            r_slot_ret[w_waddr] <= w_wret;
        end
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending result left over in idle");

    a_accept_restarts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.func != FUNC_RESV)) |=> (r_idx == '0) && (r_nout == '0))
        else $error("scan not restarted on accepted command");

    a_update_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && w_can_push) |=> r_pend_v)
        else $error("due entry produced no pending result");

    a_ack_clears_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && r_func == FUNC_ACK && r_hit)
            |=> !r_slot_valid[$past(r_slot)])
        else $error("acked slot still valid");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_pend_v && w_out_free) |=> (r_out_v && r_out_last))
        else $error("final transfer not marked last");

endmodule
